// File: design/ppt_pkg.sv
package ppt_pkg;

  // Default field widths
  localparam int COORD_WIDTH_DEF = 48;
  localparam int COEF_WIDTH_DEF  = 48;

  // Coefficient store layout: forward bank then inverse bank, row-major a..i
  localparam int NUM_SLOTS = 18;
  localparam int BANK_SLOTS = 9;
  localparam int SLOT_IDX_W = 5;

  // Fixed-point alignment
  localparam int ALIGN_SHIFT = 16;  // c/f/i to product scale, numerator to quotient scale
  localparam int LIM_SHIFT   = 32;  // Q0.16 limit to the 48-fraction-bit Z scale
  localparam int LIM_WIDTH   = 16;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XFORM = 1'b1;

  // Register map
  localparam logic REG_INV_VALID = 1'b0;
  localparam logic REG_NEAR_LIM  = 1'b1;
  localparam int   APB_ADDR_W    = 3;
  localparam int   APB_DATA_W    = 32;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_INV = 2'd1,
    ST_INF    = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  // Per-stage control travelling alongside the datapath
  typedef struct packed {
    logic valid;
    logic noinv;
  } meta_t;

  // Flags out of the divider
  typedef struct packed {
    logic sat_x;
    logic sat_y;
    logic zsmall;
  } div_flags_t;

endpackage

// File: design/ppt_req_if.sv
interface ppt_req_if import ppt_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int KW = COEF_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic        [SLOT_IDX_W-1:0] coef_index;
  logic signed [KW-1:0]         coef_value;
  logic signed [CW-1:0]         x_in;
  logic signed [CW-1:0]         y_in;
  logic                         to_source;

  modport source (output valid, req_type, coef_index, coef_value, x_in, y_in, to_source,
                  input ready);
  modport sink   (input valid, req_type, coef_index, coef_value, x_in, y_in, to_source,
                  output ready);
endinterface

// File: design/ppt_res_if.sv
interface ppt_res_if import ppt_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_out;
  logic signed [CW-1:0] y_out;
  logic        [1:0]    status;

  modport source (output valid, x_out, y_out, status, input ready);
  modport sink   (input valid, x_out, y_out, status, output ready);
endinterface

// File: design/projective_point_transform.sv
// Channel  Dir  Transaction
// req_i    in   load one coefficient (req_type 0) or map one point (req_type 1)
// res_o    out  one mapped point with status, per point request only
// APB      in   register writes/reads: inverse_valid at 0x0, near_zero_limit at 0x4
//
// One request per cycle while no result is held; a point result passes through
// 4 multiply/accumulate stages, 2 divider set-up stages, one
// restoring-division stage per quotient bit and a saturation stage.
// Loads write the store at acceptance and give no result.
// Reset clears the store, the registers and all stage valid bits.
// A held result stalls the whole pipeline; req_i.ready stays low while it is held.
module projective_point_transform import ppt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppt_req_if.sink               req_i,
  ppt_res_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int KW    = COEF_WIDTH;
  localparam int SW    = CW + KW + 2;
  localparam int DEPTH = CW + 7;

  // Configuration registers
  logic                 inv_valid_q;
  logic [LIM_WIDTH-1:0] near_lim_q;
  logic                 cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_valid_q <= 1'b0;
      near_lim_q  <= LIM_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_INV_VALID: inv_valid_q <= pwdata[0];
        REG_NEAR_LIM:  near_lim_q  <= pwdata[LIM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INV_VALID: prdata = APB_DATA_W'(inv_valid_q);
      REG_NEAR_LIM:  prdata = APB_DATA_W'(near_lim_q);
      default:       prdata = '0;
    endcase
  end

  // Global advance: moves whenever the output stage is empty or being drained
  logic en, out_valid, accept;

  assign en          = !out_valid || res_o.ready;
  assign req_i.ready = en;
  assign accept      = req_i.valid && en;

  // Coefficient store
  logic signed [KW-1:0] coef [BANK_SLOTS];

  ppt_coef_store #(.KW(KW)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept && (req_i.req_type == REQ_LOAD)),
    .widx_i  (req_i.coef_index),
    .wdata_i (req_i.coef_value),
    .bank_i  (req_i.to_source),
    .coef_o  (coef)
  );

  // Row sums: X numerator, Y numerator, Z
  logic signed [SW-1:0] row_sum [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    ppt_row_mac #(.CW(CW), .KW(KW), .SW(SW)) u_mac (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (coef[3*r]),
      .b_i   (coef[3*r + 1]),
      .c_i   (coef[3*r + 2]),
      .x_i   (req_i.x_in),
      .y_i   (req_i.y_in),
      .sum_o (row_sum[r])
    );
  end

  // Divisions by Z and small-Z detection
  logic signed [CW-1:0] qx, qy;
  div_flags_t           dflags;

  ppt_divider #(.CW(CW), .SW(SW)) u_div (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_x_i (row_sum[0]),
    .num_y_i (row_sum[1]),
    .den_i   (row_sum[2]),
    .lim_i   (near_lim_q),
    .q_x_o   (qx),
    .q_y_o   (qy),
    .flags_o (dflags)
  );

  // Valid and early status travel with the datapath
  meta_t meta_q [DEPTH];
  meta_t meta_d;

  assign meta_d.valid = accept && (req_i.req_type == REQ_XFORM);
  assign meta_d.noinv = req_i.to_source && !inv_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DEPTH; s++) meta_q[s] <= '0;
    end else if (en) begin
      meta_q[0] <= meta_d;
      for (int s = 1; s < DEPTH; s++) meta_q[s] <= meta_q[s-1];
    end
  end

  // Result formatting, status precedence: no inverse, infinity, saturated
  status_e status;
  logic    zero_out;

  assign out_valid = meta_q[DEPTH-1].valid;
  assign zero_out  = meta_q[DEPTH-1].noinv || dflags.zsmall;

  always_comb begin
    if (meta_q[DEPTH-1].noinv)             status = ST_NO_INV;
    else if (dflags.zsmall)                status = ST_INF;
    else if (dflags.sat_x || dflags.sat_y) status = ST_SAT;
    else                                   status = ST_OK;
  end

  assign res_o.valid  = out_valid;
  assign res_o.x_out  = zero_out ? '0 : qx;
  assign res_o.y_out  = zero_out ? '0 : qy;
  assign res_o.status = status;

endmodule

// File: design/ppt_coef_store.sv
module ppt_coef_store import ppt_pkg::*; #(
  parameter int KW = COEF_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic        [SLOT_IDX_W-1:0] widx_i,
  input  logic signed [KW-1:0]         wdata_i,
  input  logic                         bank_i,
  output logic signed [KW-1:0]         coef_o [BANK_SLOTS]
);

  logic signed [KW-1:0] coef_q [NUM_SLOTS];

  // Slot write; indices past the store are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) coef_q[s] <= '0;
    end else if (we_i && (widx_i < SLOT_IDX_W'(NUM_SLOTS))) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (widx_i == SLOT_IDX_W'(s)) coef_q[s] <= wdata_i;
      end
    end
  end

  // Bank select: forward or inverse matrix
  always_comb begin
    for (int j = 0; j < BANK_SLOTS; j++) begin
      coef_o[j] = bank_i ? coef_q[BANK_SLOTS + j] : coef_q[j];
    end
  end

endmodule

// File: design/ppt_row_mac.sv
module ppt_row_mac import ppt_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int KW = COEF_WIDTH_DEF,
  parameter int SW = CW + KW + 2
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [KW-1:0] a_i,
  input  logic signed [KW-1:0] b_i,
  input  logic signed [KW-1:0] c_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  output logic signed [SW-1:0] sum_o
);

  localparam int PW = CW + KW;
  localparam int KL = (KW + 1) / 2;
  localparam int KU = KW - KL;
  localparam int CL = (CW + 1) / 2;
  localparam int CU = CW - CL;

  // Stage 1: sign and magnitude
  logic [KW-1:0] a_mag_q, b_mag_q;
  logic [CW-1:0] x_mag_q, y_mag_q;
  logic          a_sg_q, b_sg_q, x_sg_q, y_sg_q;
  logic signed [KW-1:0] c1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q <= a_i[KW-1] ? KW'(-a_i) : KW'(a_i);
      b_mag_q <= b_i[KW-1] ? KW'(-b_i) : KW'(b_i);
      x_mag_q <= x_i[CW-1] ? CW'(-x_i) : CW'(x_i);
      y_mag_q <= y_i[CW-1] ? CW'(-y_i) : CW'(y_i);
      a_sg_q  <= a_i[KW-1];
      b_sg_q  <= b_i[KW-1];
      x_sg_q  <= x_i[CW-1];
      y_sg_q  <= y_i[CW-1];
      c1_q    <= c_i;
    end
  end

  // Stage 2: half-width partial products
  logic [KL+CL-1:0] a_ll_q, b_ll_q;
  logic [KL+CU-1:0] a_lu_q, b_lu_q;
  logic [KU+CL-1:0] a_ul_q, b_ul_q;
  logic [KU+CU-1:0] a_uu_q, b_uu_q;
  logic             neg_a2_q, neg_b2_q;
  logic signed [KW-1:0] c2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ll_q   <= (KL+CL)'(a_mag_q[KL-1:0])  * (KL+CL)'(x_mag_q[CL-1:0]);
      a_lu_q   <= (KL+CU)'(a_mag_q[KL-1:0])  * (KL+CU)'(x_mag_q[CW-1:CL]);
      a_ul_q   <= (KU+CL)'(a_mag_q[KW-1:KL]) * (KU+CL)'(x_mag_q[CL-1:0]);
      a_uu_q   <= (KU+CU)'(a_mag_q[KW-1:KL]) * (KU+CU)'(x_mag_q[CW-1:CL]);
      b_ll_q   <= (KL+CL)'(b_mag_q[KL-1:0])  * (KL+CL)'(y_mag_q[CL-1:0]);
      b_lu_q   <= (KL+CU)'(b_mag_q[KL-1:0])  * (KL+CU)'(y_mag_q[CW-1:CL]);
      b_ul_q   <= (KU+CL)'(b_mag_q[KW-1:KL]) * (KU+CL)'(y_mag_q[CL-1:0]);
      b_uu_q   <= (KU+CU)'(b_mag_q[KW-1:KL]) * (KU+CU)'(y_mag_q[CW-1:CL]);
      neg_a2_q <= a_sg_q ^ x_sg_q;
      neg_b2_q <= b_sg_q ^ y_sg_q;
      c2_q     <= c1_q;
    end
  end

  // Stage 3: recombine partials into full magnitudes
  logic [PW-1:0] pm_a_q, pm_b_q;
  logic          neg_a3_q, neg_b3_q;
  logic signed [KW-1:0] c3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_a_q   <= PW'(a_ll_q) + (PW'(a_lu_q) << CL) + (PW'(a_ul_q) << KL)
                  + (PW'(a_uu_q) << (KL + CL));
      pm_b_q   <= PW'(b_ll_q) + (PW'(b_lu_q) << CL) + (PW'(b_ul_q) << KL)
                  + (PW'(b_uu_q) << (KL + CL));
      neg_a3_q <= neg_a2_q;
      neg_b3_q <= neg_b2_q;
      c3_q     <= c2_q;
    end
  end

  // Stage 4: signed row sum, constant term aligned to product scale
  logic signed [SW-1:0] pa_s, pb_s, c_s;
  logic signed [SW-1:0] sum_q;

  assign pa_s = neg_a3_q ? -$signed(SW'(pm_a_q)) : $signed(SW'(pm_a_q));
  assign pb_s = neg_b3_q ? -$signed(SW'(pm_b_q)) : $signed(SW'(pm_b_q));
  assign c_s  = SW'(c3_q) <<< ALIGN_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en_i) sum_q <= pa_s + pb_s + c_s;
  end

  assign sum_o = sum_q;

endmodule

// File: design/ppt_divider.sv
module ppt_divider import ppt_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int SW = 2 * COORD_WIDTH_DEF + 2
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [SW-1:0] num_x_i,
  input  logic signed [SW-1:0] num_y_i,
  input  logic signed [SW-1:0] den_i,
  input  logic [LIM_WIDTH-1:0] lim_i,
  output logic signed [CW-1:0] q_x_o,
  output logic signed [CW-1:0] q_y_o,
  output div_flags_t           flags_o
);

  localparam int RW = SW + CW;

  // Saturate and apply sign; returns {sat, value}
  function automatic logic [CW:0] fmt(input logic [CW-1:0] q, input logic neg,
                                      input logic ov);
    logic pos_sat, neg_sat;
    logic [CW-1:0] v;
    pos_sat = ov || q[CW-1];
    neg_sat = ov || (q[CW-1] && (q[CW-2:0] != '0));
    if (neg) v = neg_sat ? {1'b1, {(CW-1){1'b0}}} : CW'(-q);
    else     v = pos_sat ? {1'b0, {(CW-1){1'b1}}} : q;
    return {(neg ? neg_sat : pos_sat), v};
  endfunction

  // Stage 0: magnitudes, numerator scaled for 16 quotient fraction bits
  logic [SW-1:0] mx, my, md;
  logic [RW-1:0] nx0_q, ny0_q;
  logic [SW-1:0] d0_q;
  logic          negx0_q, negy0_q;

  assign mx = num_x_i[SW-1] ? SW'(-num_x_i) : SW'(num_x_i);
  assign my = num_y_i[SW-1] ? SW'(-num_y_i) : SW'(num_y_i);
  assign md = den_i[SW-1]   ? SW'(-den_i)   : SW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx0_q   <= RW'(mx) << ALIGN_SHIFT;
      ny0_q   <= RW'(my) << ALIGN_SHIFT;
      d0_q    <= md;
      negx0_q <= num_x_i[SW-1] ^ den_i[SW-1];
      negy0_q <= num_y_i[SW-1] ^ den_i[SW-1];
    end
  end

  // Per-step pipeline registers, step 0 is the division start
  logic [RW-1:0] rem_x_q [CW+1];
  logic [RW-1:0] rem_y_q [CW+1];
  logic [CW-1:0] q_x_q   [CW+1];
  logic [CW-1:0] q_y_q   [CW+1];
  logic [SW-1:0] d_q     [CW+1];
  logic [CW:0]   negx_q, negy_q, ovx_q, ovy_q, zsm_q;

  // Stage 1: quotient range check and small-Z check
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_x_q[0] <= nx0_q;
      rem_y_q[0] <= ny0_q;
      q_x_q[0]   <= '0;
      q_y_q[0]   <= '0;
      d_q[0]     <= d0_q;
      negx_q[0]  <= negx0_q;
      negy_q[0]  <= negy0_q;
      ovx_q[0]   <= nx0_q >= (RW'(d0_q) << CW);
      ovy_q[0]   <= ny0_q >= (RW'(d0_q) << CW);
      zsm_q[0]   <= (d0_q == '0) || (d0_q < (SW'(lim_i) << LIM_SHIFT));
    end
  end

  // One quotient bit per stage, MSB first
  for (genvar j = 0; j < CW; j++) begin : g_bit
    localparam int K = CW - 1 - j;
    logic [RW-1:0] trial;
    logic          fit_x, fit_y;

    assign trial = RW'(d_q[j]) << K;
    assign fit_x = rem_x_q[j] >= trial;
    assign fit_y = rem_y_q[j] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_x_q[j+1] <= fit_x ? rem_x_q[j] - trial : rem_x_q[j];
        rem_y_q[j+1] <= fit_y ? rem_y_q[j] - trial : rem_y_q[j];
        q_x_q[j+1]   <= q_x_q[j] | (fit_x ? (CW'(1) << K) : '0);
        q_y_q[j+1]   <= q_y_q[j] | (fit_y ? (CW'(1) << K) : '0);
        d_q[j+1]     <= d_q[j];
        negx_q[j+1]  <= negx_q[j];
        negy_q[j+1]  <= negy_q[j];
        ovx_q[j+1]   <= ovx_q[j];
        ovy_q[j+1]   <= ovy_q[j];
        zsm_q[j+1]   <= zsm_q[j];
      end
    end
  end

  // Final stage: saturation and sign
  logic [CW:0]   fx, fy;
  logic [CW-1:0] qx_out_q, qy_out_q;
  div_flags_t    flags_q;

  assign fx = fmt(q_x_q[CW], negx_q[CW], ovx_q[CW]);
  assign fy = fmt(q_y_q[CW], negy_q[CW], ovy_q[CW]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_out_q       <= fx[CW-1:0];
      qy_out_q       <= fy[CW-1:0];
      flags_q.sat_x  <= fx[CW];
      flags_q.sat_y  <= fy[CW];
      flags_q.zsmall <= zsm_q[CW];
    end
  end

  assign q_x_o   = $signed(qx_out_q);
  assign q_y_o   = $signed(qy_out_q);
  assign flags_o = flags_q;

endmodule

// File: bench/projective_point_transform_tb.sv
`timescale 1ns / 1ps

module projective_point_transform_tb;
  import ppt_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int KW = COEF_WIDTH_DEF;
  localparam int PIPE_DEPTH = CW + 7;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic                  req_type;
    logic [SLOT_IDX_W-1:0] coef_index;
    logic signed [KW-1:0]  coef_value;
    logic signed [CW-1:0]  x_in;
    logic signed [CW-1:0]  y_in;
    logic                  to_source;
  } point_req_t;

  typedef struct {
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    status_e              status;
  } mapped_point_t;

  // Homography model: own copy of the store and registers, queue of mapped points
  class homography_predictor;
    logic signed [KW-1:0] coef_bank[NUM_SLOTS];
    logic                 inv_valid;
    logic [LIM_WIDTH-1:0] near_lim;
    mapped_point_t        pending_points[$];
    int                   errors;

    function void clear();
      foreach (coef_bank[i]) coef_bank[i] = '0;
      inv_valid = 1'b0;
      near_lim  = 16'd1;
      errors    = 0;
    endfunction

    function void write_reg(logic sel, logic [31:0] val);
      if (sel == REG_INV_VALID) inv_valid = val[0];
      else near_lim = val[LIM_WIDTH-1:0];
    endfunction

    // a*x + b*y + (c << 16), exact at 48 fraction bits
    function wide_t row_product(int base, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      wide_t ka, kb, kc, wx, wy;
      ka = coef_bank[base];
      kb = coef_bank[base+1];
      kc = coef_bank[base+2];
      wx = x;
      wy = y;
      return ka * wx + kb * wy + (kc <<< ALIGN_SHIFT);
    endfunction

    // truncating divide, then saturate to the coordinate width
    function logic signed [CW-1:0] divide_sat(wide_t num, wide_t z, ref logic sat);
      logic        neg;
      wide_t       n;
      logic [191:0] an, az, q, lim;
      logic signed [CW-1:0] v;
      neg = num[191] ^ z[191];
      n   = num <<< ALIGN_SHIFT;
      an  = n[191] ? -n : n;
      az  = z[191] ? -z : z;
      q   = an / az;
      lim = 192'(1) << (CW - 1);
      if (!neg && q >= lim) begin
        sat = 1'b1;
        return {1'b0, {(CW-1){1'b1}}};
      end
      if (neg && q > lim) begin
        sat = 1'b1;
        return {1'b1, {(CW-1){1'b0}}};
      end
      v = q[CW-1:0];
      return neg ? -v : v;
    endfunction

    function void note_input(point_req_t r);
      mapped_point_t m;
      int            base;
      wide_t         z, az;
      logic          sat;
      if (r.req_type == REQ_LOAD) begin
        if (r.coef_index < NUM_SLOTS) coef_bank[r.coef_index] = r.coef_value;
        return;
      end
      m.x_out = '0;
      m.y_out = '0;
      sat = 1'b0;
      if (r.to_source && !inv_valid) begin
        m.status = ST_NO_INV;
      end else begin
        base = r.to_source ? BANK_SLOTS : 0;
        z  = row_product(base + 6, r.x_in, r.y_in);
        az = z[191] ? -z : z;
        if (z == '0 || az < (wide_t'(near_lim) << LIM_SHIFT)) begin
          m.status = ST_INF;
        end else begin
          m.x_out  = divide_sat(row_product(base, r.x_in, r.y_in), z, sat);
          m.y_out  = divide_sat(row_product(base + 3, r.x_in, r.y_in), z, sat);
          m.status = sat ? ST_SAT : ST_OK;
        end
      end
      pending_points.push_back(m);
    endfunction

    function void check_result(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic [1:0] st);
      mapped_point_t m;
      if (pending_points.size() == 0) begin
        $error("unexpected result x_out=%0d y_out=%0d status=%0d", x, y, st);
        errors++;
        return;
      end
      m = pending_points.pop_front();
      if (x !== m.x_out) begin
        $error("x_out expected %0d actual %0d", m.x_out, x);
        errors++;
      end
      if (y !== m.y_out) begin
        $error("y_out expected %0d actual %0d", m.y_out, y);
        errors++;
      end
      if (st !== m.status) begin
        $error("status expected %0d actual %0d", m.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  ppt_req_if #(.CW(CW), .KW(KW)) req();
  ppt_res_if #(.CW(CW)) res();

  projective_point_transform #(.COORD_WIDTH(CW), .COEF_WIDTH(KW)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  homography_predictor model = new();
  int tx_idle_pct;
  int rx_idle_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("projective_point_transform_tb NOT OK");
    $finish;
  end

  // result side: check each transaction, random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready)
      model.check_result(res.x_out, res.y_out, res.status);
    res.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_req(point_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.req_type   <= r.req_type;
    req.coef_index <= r.coef_index;
    req.coef_value <= r.coef_value;
    req.x_in       <= r.x_in;
    req.y_in       <= r.y_in;
    req.to_source  <= r.to_source;
    do @(posedge clk_i); while (!req.ready);
    model.note_input(r);
  endtask

  task automatic load_coef(int idx, logic signed [KW-1:0] val);
    point_req_t r;
    r = '{REQ_LOAD, idx[SLOT_IDX_W-1:0], val, CW'($urandom), CW'($urandom),
          1'($urandom_range(1))};
    send_req(r);
  endtask

  task automatic map_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic src);
    point_req_t r;
    r = '{REQ_XFORM, SLOT_IDX_W'($urandom_range(31)), KW'({$urandom, $urandom}), x, y, src};
    send_req(r);
  endtask

  // setup, access, then idle so writes never overlap
  task automatic apb_write(logic sel, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= sel ? APB_ADDR_W'(4) : APB_ADDR_W'(0);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    model.write_reg(sel, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers change only with the pipeline drained
  task automatic set_regs(logic inv, logic [15:0] lim);
    req.valid <= 1'b0;
    while (model.pending_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    apb_write(REG_INV_VALID, {31'd0, inv});
    apb_write(REG_NEAR_LIM, {16'd0, lim});
  endtask

  // mixed-magnitude value: extremes, full range, or a scaled small value
  function automatic logic signed [47:0] pick_value(int span);
    logic [63:0] raw;
    logic signed [47:0] v;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 48'sh7FFF_FFFF_FFFF;
          1: v = 48'sh8000_0000_0000;
          2: v = '0;
          default: v = -48'sd1;
        endcase
      end
      1, 2: v = raw[47:0];
      default: begin
        v = 48'(raw >> (64 - span));
        if (raw[0]) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [15:0] lim;
    rst_ni      = 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 48;
    req.valid      <= 1'b0;
    req.req_type   <= REQ_LOAD;
    req.coef_index <= '0;
    req.coef_value <= '0;
    req.x_in       <= '0;
    req.y_in       <= '0;
    req.to_source  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    model.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store gives an exact zero Z, inverse without a valid inverse
    map_point(48'sd65536, 48'sd65536, 1'b0);
    map_point(48'sd0, 48'sd0, 1'b1);
    // identity forward matrix
    load_coef(0, 48'sh1_0000_0000);
    load_coef(4, 48'sh1_0000_0000);
    load_coef(8, 48'sh1_0000_0000);
    load_coef(31, 48'sh7FFF_FFFF_FFFF);          // past the store: ignored
    map_point(48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 1'b0);
    map_point(-48'sd123456, 48'sd98765, 1'b0);
    // scaled-up x with a small Z saturates
    load_coef(0, 48'sh7FFF_FFFF_FFFF);
    load_coef(8, 48'sh0_0001_0000);
    map_point(48'sh7FFF_FFFF_FFFF, 48'sd5, 1'b0);
    map_point(48'sh8000_0000_0000, -48'sd5, 1'b0);
    // inverse bank loads do not validate the inverse
    load_coef(9, 48'sh8000_0000_0000);
    load_coef(13, 48'sh1_0000_0000);
    load_coef(17, 48'sh2_0000_0000);
    map_point(48'sd65536, 48'sd65536, 1'b1);
    set_regs(1'b1, 16'hFFFF);
    map_point(48'sd655360, -48'sd655360, 1'b1);  // |Z| above the maximum limit
    load_coef(17, 48'sh7FFF_0000_0000);
    map_point(48'sd655360, -48'sd655360, 1'b1);
    set_regs(1'b1, 16'd0);
    load_coef(8, 48'sd0);
    map_point(48'sd0, 48'sd0, 1'b0);             // exact zero Z with a zero limit
    map_point(48'sd1, -48'sd1, 1'b1);

    // random: three back-pressure phases, registers changed between chunks
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 48 : 0;
      rx_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 9 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(3))
          0: lim = 16'd0;
          1: lim = 16'hFFFF;
          2: lim = 16'd1;
          default: lim = 16'($urandom_range(65535));
        endcase
        set_regs(1'($urandom_range(1)), lim);
        for (int k = 0; k < 108; k++) begin
          if ($urandom_range(3) == 0)
            load_coef(($urandom_range(15) == 0) ? $urandom_range(31) : $urandom_range(17),
                      pick_value(36));
          else
            map_point(pick_value(34), pick_value(34), 1'($urandom_range(1)));
        end
      end
    end

    req.valid <= 1'b0;
    while (model.pending_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (model.errors == 0)
      $display("projective_point_transform_tb OK");
    else
      $display("projective_point_transform_tb NOT OK");
    $finish;
  end

endmodule
